/* sv/plas_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and the arctangent step table of the launch angle solver
package plas_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_BITS    = 32;
    localparam int SPEED_W      = WORD_BITS - 1;
    localparam int ANGLE_W      = FRAC_BITS + 8;
    localparam int HALF_W       = 31;
    localparam int PROD_W       = 2 * HALF_W;
    localparam int WIDE_W       = 128;
    localparam int ROOT_W       = 64;
    localparam int REM_W        = ROOT_W + 2;
    localparam int Z_W          = 34;
    localparam int CORDIC_ITERS = 31;
    localparam int NORM_STEPS   = 6;
    localparam int NORM_TOP     = 59;
    localparam int CORDIC_LAT   = NORM_STEPS + CORDIC_ITERS + 2;
    localparam int OUT_SHIFT    = 24 - FRAC_BITS;
    localparam int QUEUE_DEPTH  = 4;
    localparam int IN_DATA_W    = 96;
    localparam int OUT_DATA_W   = 48;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [SPEED_W-1:0]        GRAVITY_RESET = 31'd642253;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIM     = 24'sd5898240;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_LIM = -24'sd5898240;
    localparam logic                      REG_GRAVITY   = 1'b0;
    localparam longint                    DEG_Q24_PER_RAD = 961263669;

    // one classified word waiting in the queue
    typedef struct packed {
        logic               degen;
        logic [SPEED_W-1:0] speed;
        logic [31:0]        dist_mag;
        logic [31:0]        height_mag;
        logic               dist_neg;
        logic               height_neg;
    } t_item;

    // values that ride alongside the square root stages
    typedef struct packed {
        logic              reach;
        logic              dist_neg;
        logic [PROD_W-1:0] speed_sq;
        logic [PROD_W-1:0] grav_dist;
    } t_side;

    // atan(2^-i) in degrees, Q.24
    function automatic logic [31:0] atan_step(input int idx);
        logic [31:0] res;
        unique case (idx)
            0:       res = 32'd754974720;
            1:       res = 32'd445687602;
            2:       res = 32'd235489088;
            3:       res = 32'd119537938;
            4:       res = 32'd60000934;
            5:       res = 32'd30029717;
            6:       res = 32'd15018523;
            7:       res = 32'd7509720;
            8:       res = 32'd3754917;
            9:       res = 32'd1877466;
            10:      res = 32'd938734;
            11:      res = 32'd469367;
            default: res = 32'((DEG_Q24_PER_RAD + (longint'(1) << (idx - 1))) >>> idx);
        endcase
        return res;
    endfunction

endpackage

/* sv/plas_front.sv */
`timescale 1ns / 1ps
// front end: takes input words, splits signs and magnitudes, flags degenerate cases
module plas_front (
    input  logic [plas_pkg::IN_DATA_W-1:0] i_data,
    input  logic                           i_valid,
    input  logic [plas_pkg::SPEED_W-1:0]   i_gravity,
    input  logic                           i_queue_full,
    output logic                           o_ready,
    output logic                           o_push,
    output plas_pkg::t_item                o_item
);

    logic [plas_pkg::SPEED_W-1:0] speed;
    logic signed [31:0]           distance;
    logic signed [31:0]           height;

    // field unpacking
    assign speed    = i_data[30:0];
    assign distance = i_data[62:31];
    assign height   = i_data[94:63];

    // handshake toward the queue
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // classification
    always_comb begin
        o_item.degen      = (speed == '0) || (i_gravity == '0) || (distance == '0);
        o_item.speed      = speed;
        o_item.dist_neg   = distance[31];
        o_item.height_neg = height[31];
        o_item.dist_mag   = distance[31] ? 32'(-distance) : 32'(distance);
        o_item.height_mag = height[31] ? 32'(-height) : 32'(height);
    end

endmodule

/* sv/plas_queue.sv */
`timescale 1ns / 1ps
// small queue between the front end and the arithmetic pipeline
module plas_queue #(
    parameter int DEPTH = plas_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plas_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output plas_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plas_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/plas_sqrt.sv */
`timescale 1ns / 1ps
// pipelined digit-by-digit floor square root, one root bit per stage
module plas_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [plas_pkg::WIDE_W-1:0]   i_radicand,
    input  plas_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [plas_pkg::ROOT_W-1:0]   o_root,
    output plas_pkg::t_side               o_side
);

    localparam int NST = plas_pkg::ROOT_W;

    logic                          r_vld  [NST];
    logic [plas_pkg::REM_W-1:0]    r_rem  [NST];
    logic [plas_pkg::ROOT_W-1:0]   r_root [NST];
    logic [plas_pkg::WIDE_W-1:0]   r_rad  [NST];
    plas_pkg::t_side               r_side [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic                          p_vld;
        logic [plas_pkg::REM_W-1:0]    p_rem;
        logic [plas_pkg::ROOT_W-1:0]   p_root;
        logic [plas_pkg::WIDE_W-1:0]   p_rad;
        plas_pkg::t_side               p_side;
        logic [plas_pkg::REM_W+1:0]    n_cand;
        logic [plas_pkg::REM_W+1:0]    n_trial;
        logic [plas_pkg::REM_W+1:0]    n_diff;
        logic                          n_ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_radicand;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb begin
            n_cand  = {p_rem, p_rad[plas_pkg::WIDE_W-1 -: 2]};
            n_trial = {2'b00, p_root, 2'b01};
            n_diff  = n_cand - n_trial;
            n_ge    = (n_cand >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[plas_pkg::REM_W-1:0] : n_cand[plas_pkg::REM_W-1:0];
                r_root[k] <= {p_root[plas_pkg::ROOT_W-2:0], n_ge};
                r_rad[k]  <= {p_rad[plas_pkg::WIDE_W-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

/* sv/plas_cordic.sv */
`timescale 1ns / 1ps
// pipelined vectoring cordic: normalize, rotate, round and clamp to degrees
module plas_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_neg,
    input  logic [63:0]                         i_ym,
    input  logic [63:0]                         i_xm,
    output logic signed [plas_pkg::ANGLE_W-1:0] o_angle
);

    localparam int NS = plas_pkg::NORM_STEPS;
    localparam int NI = plas_pkg::CORDIC_ITERS;

    logic [63:0] r_ny   [NS+1];
    logic [63:0] r_nx   [NS+1];
    logic [63:0] r_nm   [NS+1];
    logic        r_nneg [NS+1];

    logic signed [63:0]             r_x [NI];
    logic signed [63:0]             r_y [NI];
    logic signed [plas_pkg::Z_W-1:0] r_z [NI];

    logic [63:0] n_mx;
    logic [2:0]  n_rsh;

    // scale down so the larger magnitude sits below bit 60
    always_comb begin
        n_mx = (i_ym > i_xm) ? i_ym : i_xm;
        priority if (n_mx[63]) begin
            n_rsh = 3'd4;
        end else if (n_mx[62]) begin
            n_rsh = 3'd3;
        end else if (n_mx[61]) begin
            n_rsh = 3'd2;
        end else if (n_mx[60]) begin
            n_rsh = 3'd1;
        end else begin
            n_rsh = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ny[0]   <= i_ym >> n_rsh;
            r_nx[0]   <= i_xm >> n_rsh;
            r_nm[0]   <= n_mx >> n_rsh;
            r_nneg[0] <= i_neg;
        end
    end

    // left normalization, one binary step per stage
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic n_zero;
        assign n_zero = (r_nm[j][plas_pkg::NORM_TOP -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ny[j+1]   <= n_zero ? (r_ny[j] << SH) : r_ny[j];
                r_nx[j+1]   <= n_zero ? (r_nx[j] << SH) : r_nx[j];
                r_nm[j+1]   <= n_zero ? (r_nm[j] << SH) : r_nm[j];
                r_nneg[j+1] <= r_nneg[j];
            end
        end
    end

    // rotation stages
    for (genvar i = 0; i < NI; i++) begin : g_iter
        localparam logic signed [plas_pkg::Z_W-1:0] ANG =
            plas_pkg::Z_W'(plas_pkg::atan_step(i));
        logic signed [63:0]              p_x;
        logic signed [63:0]              p_y;
        logic signed [plas_pkg::Z_W-1:0] p_z;
        logic signed [63:0]              n_xs;
        logic signed [63:0]              n_ys;

        if (i == 0) begin : g_first
            assign p_x = signed'(r_nx[NS]);
            assign p_y = r_nneg[NS] ? -signed'(r_ny[NS]) : signed'(r_ny[NS]);
            assign p_z = '0;
        end else begin : g_next
            assign p_x = r_x[i-1];
            assign p_y = r_y[i-1];
            assign p_z = r_z[i-1];
        end

        assign n_xs = p_x >>> i;
        assign n_ys = p_y >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p_y > 0) begin
                    r_x[i] <= p_x + n_ys;
                    r_y[i] <= p_y - n_xs;
                    r_z[i] <= p_z + ANG;
                end else begin
                    r_x[i] <= p_x - n_ys;
                    r_y[i] <= p_y + n_xs;
                    r_z[i] <= p_z - ANG;
                end
            end
        end
    end

    logic signed [plas_pkg::Z_W-1:0] n_zr;
    logic signed [plas_pkg::Z_W-1:0] n_zs;

    // round half up to the output grid and limit to +-90 degrees
    always_comb begin
        n_zr = r_z[NI-1] + plas_pkg::Z_W'(1 << (plas_pkg::OUT_SHIFT - 1));
        n_zs = n_zr >>> plas_pkg::OUT_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_zs > plas_pkg::Z_W'(plas_pkg::ANGLE_LIM)) begin
                o_angle <= plas_pkg::ANGLE_LIM;
            end else if (n_zs < plas_pkg::Z_W'(plas_pkg::ANGLE_NEG_LIM)) begin
                o_angle <= plas_pkg::ANGLE_NEG_LIM;
            end else begin
                o_angle <= n_zs[plas_pkg::ANGLE_W-1:0];
            end
        end
    end

endmodule

/* sv/plas_back.sv */
`timescale 1ns / 1ps
// back end: discriminant, square root, two cordic channels, sort and output register
module plas_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  plas_pkg::t_item                     i_item,
    input  logic [plas_pkg::SPEED_W-1:0]        i_gravity,
    input  logic                                i_ready,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic                                o_reach,
    output logic signed [plas_pkg::ANGLE_W-1:0] o_low,
    output logic signed [plas_pkg::ANGLE_W-1:0] o_high
);

    localparam int PW = plas_pkg::PROD_W;
    localparam int HW = plas_pkg::HALF_W;
    localparam int WW = plas_pkg::WIDE_W;
    localparam int CL = plas_pkg::CORDIC_LAT;

    logic en;

    // the whole pipeline moves unless the output word is held
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    // stage 1: squares and products of the inputs
    logic [62:0]   n_v2, n_gd, n_gh;
    logic          r1_vld, r1_ok, r1_dneg, r1_hneg;
    logic [PW-1:0] r1_v2, r1_gd, r1_gh;

    assign n_v2 = i_item.speed * i_item.speed;
    assign n_gd = i_gravity * i_item.dist_mag;
    assign n_gh = i_gravity * i_item.height_mag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok   <= !i_item.degen;
            r1_dneg <= i_item.dist_neg;
            r1_hneg <= i_item.height_neg;
            r1_v2   <= n_v2[PW-1:0];
            r1_gd   <= n_gd[PW-1:0];
            r1_gh   <= n_gh[PW-1:0];
        end
    end

    // stage 2: partial products of the wide squares
    logic          r2_vld, r2_ok, r2_dneg, r2_hneg;
    logic [PW-1:0] r2_v2, r2_gd;
    logic [PW-1:0] r2_vv_ll, r2_vv_lh, r2_vv_hh;
    logic [PW-1:0] r2_gg_ll, r2_gg_lh, r2_gg_hh;
    logic [PW-1:0] r2_t_ll, r2_t_lh, r2_t_hl, r2_t_hh;
    logic [PW-1:0] n_vv_ll, n_vv_lh, n_vv_hh, n_gg_ll, n_gg_lh, n_gg_hh;
    logic [PW-1:0] n_t_ll, n_t_lh, n_t_hl, n_t_hh;

    always_comb begin
        n_vv_ll = r1_v2[HW-1:0]  * r1_v2[HW-1:0];
        n_vv_lh = r1_v2[HW-1:0]  * r1_v2[PW-1:HW];
        n_vv_hh = r1_v2[PW-1:HW] * r1_v2[PW-1:HW];
        n_gg_ll = r1_gd[HW-1:0]  * r1_gd[HW-1:0];
        n_gg_lh = r1_gd[HW-1:0]  * r1_gd[PW-1:HW];
        n_gg_hh = r1_gd[PW-1:HW] * r1_gd[PW-1:HW];
        n_t_ll  = r1_gh[HW-1:0]  * r1_v2[HW-1:0];
        n_t_lh  = r1_gh[HW-1:0]  * r1_v2[PW-1:HW];
        n_t_hl  = r1_gh[PW-1:HW] * r1_v2[HW-1:0];
        n_t_hh  = r1_gh[PW-1:HW] * r1_v2[PW-1:HW];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok    <= r1_ok;
            r2_dneg  <= r1_dneg;
            r2_hneg  <= r1_hneg;
            r2_v2    <= r1_v2;
            r2_gd    <= r1_gd;
            r2_vv_ll <= n_vv_ll;
            r2_vv_lh <= n_vv_lh;
            r2_vv_hh <= n_vv_hh;
            r2_gg_ll <= n_gg_ll;
            r2_gg_lh <= n_gg_lh;
            r2_gg_hh <= n_gg_hh;
            r2_t_ll  <= n_t_ll;
            r2_t_lh  <= n_t_lh;
            r2_t_hl  <= n_t_hl;
            r2_t_hh  <= n_t_hh;
        end
    end

    // stage 3: v^4, (g*d)^2 and 2*g*|h|*v^2 assembled
    logic          r3_vld, r3_ok, r3_dneg, r3_hneg;
    logic [PW-1:0] r3_v2, r3_gd;
    logic [WW-1:0] r3_p, r3_q, r3_t;
    logic [PW:0]   n_mid;
    logic [WW-1:0] n_p, n_q, n_t;

    always_comb begin
        n_p   = {4'b0, r2_vv_hh, r2_vv_ll} + (WW'(r2_vv_lh) << 32);
        n_q   = {4'b0, r2_gg_hh, r2_gg_ll} + (WW'(r2_gg_lh) << 32);
        n_mid = r2_t_lh + r2_t_hl;
        n_t   = ({4'b0, r2_t_hh, r2_t_ll} + (WW'(n_mid) << 31)) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok   <= r2_ok;
            r3_dneg <= r2_dneg;
            r3_hneg <= r2_hneg;
            r3_v2   <= r2_v2;
            r3_gd   <= r2_gd;
            r3_p    <= n_p;
            r3_q    <= n_q;
            r3_t    <= n_t;
        end
    end

    // stage 4: height term goes to the side its sign calls for
    logic          r4_vld, r4_ok, r4_dneg;
    logic [PW-1:0] r4_v2, r4_gd;
    logic [WW-1:0] r4_p, r4_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok   <= r3_ok;
            r4_dneg <= r3_dneg;
            r4_v2   <= r3_v2;
            r4_gd   <= r3_gd;
            r4_p    <= r3_hneg ? r3_p + r3_t : r3_p;
            r4_q    <= r3_hneg ? r3_q : r3_q + r3_t;
        end
    end

    // stage 5: discriminant and its sign
    logic            r5_vld;
    logic [WW-1:0]   r5_e;
    plas_pkg::t_side r5_side;
    logic [WW:0]     n_diff;

    assign n_diff = {1'b0, r4_p} - {1'b0, r4_q};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_e              <= n_diff[WW-1:0];
            r5_side.reach     <= r4_ok && !n_diff[WW];
            r5_side.dist_neg  <= r4_dneg;
            r5_side.speed_sq  <= r4_v2;
            r5_side.grav_dist <= r4_gd;
        end
    end

    // control valids of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // square root of the discriminant
    logic                        s_vld;
    logic [plas_pkg::ROOT_W-1:0] s_root;
    plas_pkg::t_side             s_side;

    plas_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r5_vld),
        .i_radicand (r5_e),
        .i_side     (r5_side),
        .o_valid    (s_vld),
        .o_root     (s_root),
        .o_side     (s_side)
    );

    // numerators of both roots with their signs
    logic        rm_vld, rm_reach, rm_neg1, rm_neg2;
    logic [63:0] rm_ym1, rm_ym2, rm_xm;
    logic [63:0] n_v2w;
    logic        n_gt;

    assign n_v2w = {2'b00, s_side.speed_sq};
    assign n_gt  = (s_root > n_v2w);

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_reach <= s_side.reach;
            rm_neg1  <= s_side.dist_neg;
            rm_neg2  <= n_gt ^ s_side.dist_neg;
            rm_ym1   <= n_v2w + s_root;
            rm_ym2   <= n_gt ? s_root - n_v2w : n_v2w - s_root;
            rm_xm    <= {2'b00, s_side.grav_dist};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else if (en) begin
            rm_vld <= s_vld;
        end
    end

    // two angle channels
    logic signed [plas_pkg::ANGLE_W-1:0] c_a1, c_a2;

    plas_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_neg   (rm_neg1),
        .i_ym    (rm_ym1),
        .i_xm    (rm_xm),
        .o_angle (c_a1)
    );

    plas_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_neg   (rm_neg2),
        .i_ym    (rm_ym2),
        .i_xm    (rm_xm),
        .o_angle (c_a2)
    );

    // valid and reach flags follow the cordic latency
    logic r_dly_vld   [CL];
    logic r_dly_reach [CL];

    for (genvar k = 0; k < CL; k++) begin : g_dly
        logic p_vld, p_reach;
        if (k == 0) begin : g_first
            assign p_vld   = rm_vld;
            assign p_reach = rm_reach;
        end else begin : g_next
            assign p_vld   = r_dly_vld[k-1];
            assign p_reach = r_dly_reach[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly_vld[k] <= 1'b0;
            end else if (en) begin
                r_dly_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dly_reach[k] <= p_reach;
            end
        end
    end

    // sort into the output register, zeros when out of reach
    logic n_swap;
    assign n_swap = (c_a1 > c_a2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dly_vld[CL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_reach <= r_dly_reach[CL-1];
            if (!r_dly_reach[CL-1]) begin
                o_low  <= '0;
                o_high <= '0;
            end else begin
                o_low  <= n_swap ? c_a2 : c_a1;
                o_high <= n_swap ? c_a1 : c_a2;
            end
        end
    end

endmodule

/* sv/projectile_launch_angle_solver_top.sv */
`timescale 1ns / 1ps
// top level of the projectile launch angle solver
//
//   channel   direction  signals                        content
//   s_axis    in         tvalid tready tdata[95:0]      speed, distance, height
//   m_axis    out        tvalid tready tdata[47:0] tuser low/high angle, reachable
//   apb       in/out     psel penable pwrite paddr ...  gravity at byte address 0
//
// one word per cycle sustained while the output is taken; a word passes from
// acceptance to the output register through the 64-stage square root and the
// 39-stage cordic channels. synchronous active-low reset empties queue and pipeline;
// gravity returns to about 9.8. a held output word stalls the whole pipeline,
// and the input side keeps taking words until the four-entry queue is full.
module projectile_launch_angle_solver_top #(
    parameter int QUEUE_DEPTH = plas_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // speed[30:0], distance[62:31], height[94:63], pad
    input  logic [plas_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // low_angle[23:0], high_angle[47:24]
    output logic [plas_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // reachable[0]
    output logic                                m_axis_tuser,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plas_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [plas_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [plas_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [plas_pkg::SPEED_W-1:0] r_gravity;
    logic                         n_cfg_wr;

    // register port
    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == plas_pkg::REG_GRAVITY) ? {1'b0, r_gravity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= plas_pkg::GRAVITY_RESET;
        end else if (n_cfg_wr && (paddr[2] == plas_pkg::REG_GRAVITY)) begin
            r_gravity <= pwdata[plas_pkg::SPEED_W-1:0];
        end
    end

    // front end and queue
    plas_pkg::t_item f_item, q_item;
    logic            f_push, q_valid, q_full, q_pop;

    plas_front u_front (
        .i_data       (s_axis_tdata),
        .i_valid      (s_axis_tvalid),
        .i_gravity    (r_gravity),
        .i_queue_full (q_full),
        .o_ready      (s_axis_tready),
        .o_push       (f_push),
        .o_item       (f_item)
    );

    plas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    // arithmetic back end
    logic signed [plas_pkg::ANGLE_W-1:0] b_low, b_high;

    plas_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .i_gravity (r_gravity),
        .i_ready   (m_axis_tready),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .o_reach   (m_axis_tuser),
        .o_low     (b_low),
        .o_high    (b_high)
    );

    assign m_axis_tdata = {b_high, b_low};

    // checks on results
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("unreachable word carries nonzero angles");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (b_low <= b_high))
        else $error("angles out of order");

    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((b_low >= plas_pkg::ANGLE_NEG_LIM) &&
                           (b_high <= plas_pkg::ANGLE_LIM)))
        else $error("angle beyond ninety degrees");

endmodule
